### sv/double_ended_queue_unit_assert.svh
// Assertion macros used by the checker file.
`ifndef DOUBLE_ENDED_QUEUE_UNIT_ASSERT_SVH
`define DOUBLE_ENDED_QUEUE_UNIT_ASSERT_SVH

// Same-cycle implication, checked while out of reset.
`define DQU_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked while out of reset.
`define DQU_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/dqu_pkg.sv
package dqu_pkg;

  // Field widths of the word formats.
  localparam int DATA_W = 32;
  localparam int OP_W   = 3;
  localparam int ST_W   = 2;
  localparam int OCC_W  = 5;

  // Default number of slots in the ring.
  localparam int DEPTH_DEFAULT = 16;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
  localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
  localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;
  localparam logic [OP_W-1:0] OP_CLEAR      = 3'd4;

  // Status codes.
  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

  // Input word.
  typedef struct packed {
    logic [OP_W-1:0]          opcode;
    logic signed [DATA_W-1:0] push_value;
  } dqu_in_word_t;

  // Result word.
  typedef struct packed {
    logic [ST_W-1:0]          status;
    logic signed [DATA_W-1:0] popped_value;
    logic [OCC_W-1:0]         occupancy;
  } dqu_out_word_t;

  // Controller states.
  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_LOAD
  } dqu_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic exec;
    logic load;
  } dqu_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_busy;
  } dqu_stat_t;

endpackage

### sv/dqu_ctrl.sv
module dqu_ctrl
  import dqu_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  dqu_stat_t stat,
  output dqu_cmd_t  cmd
);

  dqu_state_t state_r;
  dqu_state_t state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state: take a word, run it against the ring, then hand off the result.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        state_nxt = S_LOAD;
      end
      S_LOAD: begin
        if (!stat.out_busy) state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Outputs decoded from the current state.
  always_comb begin
    in_ready    = 1'b0;
    cmd.capture = 1'b0;
    cmd.exec    = 1'b0;
    cmd.load    = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
      end
      S_LOAD: begin
        cmd.load = !stat.out_busy;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

### sv/dqu_dp.sv
module dqu_dp
  import dqu_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEFAULT
)
(
  input  logic          clk,
  input  logic          rst_n,
  input  dqu_cmd_t      cmd,
  output dqu_stat_t     stat,
  input  dqu_in_word_t  in_word,
  output logic          out_valid,
  input  logic          out_ready,
  output dqu_out_word_t out_word
);

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  // Ring index steps with wrap at the last slot.
  function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] i);
    return (i == IDX_LAST) ? '0 : i + 1'b1;
  endfunction

  function automatic logic [IDX_W-1:0] idx_dec(input logic [IDX_W-1:0] i);
    return (i == '0) ? IDX_LAST : i - 1'b1;
  endfunction

  logic [OP_W-1:0]   op_r;
  logic [DATA_W-1:0] val_r;
  logic [IDX_W-1:0]  front_r, front_nxt;
  logic [IDX_W-1:0]  back_r, back_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [ST_W-1:0]   status_r, status_nxt;
  logic              pop_ok_r, pop_ok_nxt;
  logic [DATA_W-1:0] slots_r [DEPTH];
  logic [DATA_W-1:0] rd_data_r;
  logic              out_valid_r;
  dqu_out_word_t     out_word_r, out_word_nxt;

  logic              wr_en, rd_en;
  logic [IDX_W-1:0]  wr_addr, rd_addr;
  logic              is_full, is_empty;

  // Capture the accepted word.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r  <= in_word.opcode;
      val_r <= in_word.push_value;
    end
  end

  assign is_full  = (count_r == CNT_FULL);
  assign is_empty = (count_r == '0);

  // Decode the operation against the current indices and count.
  always_comb begin
    front_nxt  = front_r;
    back_nxt   = back_r;
    count_nxt  = count_r;
    status_nxt = ST_OK;
    pop_ok_nxt = 1'b0;
    wr_en      = 1'b0;
    rd_en      = 1'b0;
    wr_addr    = idx_dec(front_r);
    rd_addr    = front_r;
    case (op_r)
      OP_PUSH_FRONT: begin
        if (is_full) begin
          status_nxt = ST_FULL;
        end else begin
          front_nxt = idx_dec(front_r);
          wr_addr   = idx_dec(front_r);
          wr_en     = cmd.exec;
          count_nxt = count_r + 1'b1;
        end
      end
      OP_PUSH_BACK: begin
        if (is_full) begin
          status_nxt = ST_FULL;
        end else begin
          back_nxt  = idx_inc(back_r);
          wr_addr   = idx_inc(back_r);
          wr_en     = cmd.exec;
          count_nxt = count_r + 1'b1;
        end
      end
      OP_POP_FRONT: begin
        if (is_empty) begin
          status_nxt = ST_EMPTY;
        end else begin
          rd_addr    = front_r;
          rd_en      = cmd.exec;
          pop_ok_nxt = 1'b1;
          front_nxt  = idx_inc(front_r);
          count_nxt  = count_r - 1'b1;
        end
      end
      OP_POP_BACK: begin
        if (is_empty) begin
          status_nxt = ST_EMPTY;
        end else begin
          rd_addr    = back_r;
          rd_en      = cmd.exec;
          pop_ok_nxt = 1'b1;
          back_nxt   = idx_dec(back_r);
          count_nxt  = count_r - 1'b1;
        end
      end
      OP_CLEAR: begin
        front_nxt = '0;
        back_nxt  = IDX_LAST;
        count_nxt = '0;
      end
      default: begin
        status_nxt = ST_OK;
      end
    endcase
  end

  // Ring state, updated once per word.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r <= '0;
      back_r  <= IDX_LAST;
      count_r <= '0;
    end else if (cmd.exec) begin
      front_r <= front_nxt;
      back_r  <= back_nxt;
      count_r <= count_nxt;
    end
  end

  // Per-word result flags.
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      status_r <= status_nxt;
      pop_ok_r <= pop_ok_nxt;
    end
  end

  // Slot memory with one write port and a registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      slots_r[wr_addr] <= val_r;
    end
    if (rd_en) begin
      rd_data_r <= slots_r[rd_addr];
    end
  end

  // Assemble the result word.
  always_comb begin
    out_word_nxt.status       = status_r;
    out_word_nxt.popped_value = pop_ok_r ? rd_data_r : '0;
    out_word_nxt.occupancy    = OCC_W'(count_r);
  end

  // Output register holds the result until it is taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_word_r <= out_word_nxt;
    end
  end

  assign stat.out_busy = out_valid_r && !out_ready;
  assign out_valid     = out_valid_r;
  assign out_word      = out_word_r;

endmodule

### sv/double_ended_queue_unit.sv
// Each word is captured, then run against the ring, then its result is loaded
// into the output register; a new word is taken only after that load.
// The registered read port of the slot memory sets the ring access step.
// A stalled result holds the load step until the output register is free.
// Reset: synchronous, active low; the queue comes up empty with the front index
// at zero and the back index at DEPTH-1. Slot contents are not cleared.
module double_ended_queue_unit
  import dqu_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEFAULT
)
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  dqu_in_word_t  in_word,
  output logic          out_valid,
  input  logic          out_ready,
  output dqu_out_word_t out_word
);

  dqu_cmd_t  cmd;
  dqu_stat_t stat;

  // Sequencing of each word.
  dqu_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Ring indices, count, slot memory and output register.
  dqu_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word)
  );

endmodule

### sv/dqu_checker.sv
`include "double_ended_queue_unit_assert.svh"

module dqu_checker
  import dqu_pkg::*;
(
  input logic          clk,
  input logic          rst_n,
  input logic          in_valid,
  input logic          in_ready,
  input logic          out_valid,
  input logic          out_ready,
  input dqu_out_word_t out_word
);

  logic out_stall;
  logic in_take;
  logic res_empty;
  logic res_full;
  logic empty_clean;

  // Handshake and result conditions used by the properties.
  assign out_stall   = out_valid && !out_ready;
  assign in_take     = in_valid && in_ready;
  assign res_empty   = out_valid && (out_word.status == ST_EMPTY);
  assign res_full    = out_valid && (out_word.status == ST_FULL);
  assign empty_clean = (out_word.popped_value == '0) && (out_word.occupancy == '0);

  // A stalled result word holds.
  `DQU_ASSERT_NXT(a_out_hold, out_stall, out_valid && $stable(out_word), "result word moved")

  // One word is in flight at a time, so ready drops after an accept.
  `DQU_ASSERT_NXT(a_one_in_flight, in_take, !in_ready, "second word taken while busy")

  // An empty pop leaves nothing held and returns zero.
  `DQU_ASSERT_IMP(a_empty_result, res_empty, empty_clean, "bad empty result")

  // A rejected push returns no word.
  `DQU_ASSERT_IMP(a_full_result, res_full, out_word.popped_value == '0, "bad full result")

endmodule

bind double_ended_queue_unit dqu_checker u_dqu_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_word  (out_word)
);

### dv/tb_double_ended_queue_unit.sv
`timescale 1ns / 1ps

module tb_double_ended_queue_unit;
  import dqu_pkg::*;

  localparam int DEPTH          = DEPTH_DEFAULT;
  localparam int CLK_PERIOD     = 4;
  localparam int RESET_CYCLES   = 12;
  localparam int RANDOM_WORDS   = 750;
  localparam int DRAIN_CYCLES   = 12;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int MAX_PRINTED    = 30;

  // Opcodes that the block treats as no operation.
  localparam logic [OP_W-1:0] OP_SPARE_LO  = 3'd5;
  localparam logic [OP_W-1:0] OP_SPARE_MID = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_HI  = 3'd7;

  localparam logic signed [DATA_W-1:0] WORD_MIN = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] WORD_MAX = 32'sh7FFF_FFFF;

  typedef enum int {
    MODE_FILL,
    MODE_DRAIN,
    MODE_MIX
  } stim_mode_e;

  // Tracks the ring contents and holds the result words still to come.
  class deque_scoreboard;
    logic signed [DATA_W-1:0] ring_slots [DEPTH];
    int unsigned head_pos;
    int unsigned tail_pos;
    int unsigned held;
    dqu_out_word_t expected_results [$];
    int mismatches;

    function new();
      head_pos   = 0;
      tail_pos   = DEPTH - 1;
      held       = 0;
      mismatches = 0;
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    task report(input string what);
      if (mismatches < MAX_PRINTED) begin
        $display("[%0t] mismatch: %s", $time, what);
      end
      mismatches++;
    endtask

    // Applies one accepted operation to the ring and queues its result word.
    function void note_word(input dqu_in_word_t w);
      dqu_out_word_t r;
      r.status       = ST_OK;
      r.popped_value = '0;
      case (w.opcode)
        OP_PUSH_FRONT: begin
          if (held >= DEPTH) begin
            r.status = ST_FULL;
          end else begin
            head_pos = (head_pos + DEPTH - 1) % DEPTH;
            ring_slots[head_pos] = w.push_value;
            held++;
          end
        end
        OP_PUSH_BACK: begin
          if (held >= DEPTH) begin
            r.status = ST_FULL;
          end else begin
            tail_pos = (tail_pos + 1) % DEPTH;
            ring_slots[tail_pos] = w.push_value;
            held++;
          end
        end
        OP_POP_FRONT: begin
          if (held == 0) begin
            r.status = ST_EMPTY;
          end else begin
            r.popped_value = ring_slots[head_pos];
            head_pos = (head_pos + 1) % DEPTH;
            held--;
          end
        end
        OP_POP_BACK: begin
          if (held == 0) begin
            r.status = ST_EMPTY;
          end else begin
            r.popped_value = ring_slots[tail_pos];
            tail_pos = (tail_pos + DEPTH - 1) % DEPTH;
            held--;
          end
        end
        OP_CLEAR: begin
          // Slot contents survive a clear; only the indices and count reset.
          head_pos = 0;
          tail_pos = DEPTH - 1;
          held     = 0;
        end
        default: begin
        end
      endcase
      r.occupancy = OCC_W'(held);
      expected_results.push_back(r);
    endfunction

    // Compares one accepted result word against the oldest expectation.
    task check_result(input dqu_out_word_t got);
      dqu_out_word_t want;
      if (expected_results.size() == 0) begin
        report("result word arrived with nothing expected");
        return;
      end
      want = expected_results.pop_front();
      if (got.status !== want.status) begin
        report($sformatf("status got %0d want %0d", got.status, want.status));
      end
      if (got.popped_value !== want.popped_value) begin
        report($sformatf("popped_value got %0d want %0d",
                         got.popped_value, want.popped_value));
      end
      if (got.occupancy !== want.occupancy) begin
        report($sformatf("occupancy got %0d want %0d", got.occupancy, want.occupancy));
      end
    endtask
  endclass

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          in_valid = 1'b0;
  logic          in_ready;
  dqu_in_word_t  in_word = '0;
  logic          out_valid;
  logic          out_ready = 1'b0;
  dqu_out_word_t out_word;

  deque_scoreboard tracker = new();

  int unsigned burst_left = 0;
  bit          steady = 1'b0;
  int unsigned rx_phase_left = 0;
  int unsigned rx_ready_pct = 100;
  int unsigned quiet_cycles = 0;

  double_ended_queue_unit #(
    .DEPTH(DEPTH)
  ) uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_word(in_word),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_word(out_word)
  );

  always #(CLK_PERIOD / 2.0) clk = ~clk;

  // Both channels are observed at the edge where their handshake completes.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready === 1'b1) begin
        tracker.note_word(in_word);
      end
      if (out_valid === 1'b1 && out_ready) begin
        tracker.check_result(out_word);
      end
    end
  end

  // The receiver switches between phases of different readiness.
  always @(posedge clk) begin
    if (rx_phase_left == 0) begin
      case ($urandom_range(0, 3))
        0: rx_ready_pct = 100;
        1: rx_ready_pct = 75;
        2: rx_ready_pct = 40;
        default: rx_ready_pct = 8;
      endcase
      rx_phase_left = $urandom_range(8, 80);
    end else begin
      rx_phase_left--;
    end
    out_ready <= ($urandom_range(1, 100) <= rx_ready_pct);
  end

  // Ends the run if no word moves on either channel for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready === 1'b1) || (out_valid === 1'b1 && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == WATCHDOG_LIMIT) begin
        $display("[%0t] watchdog: no handshake for %0d cycles, %0d results outstanding",
                 $time, WATCHDOG_LIMIT, tracker.pending());
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  function automatic dqu_in_word_t word_of(input logic [OP_W-1:0] op,
                                           input logic signed [DATA_W-1:0] val);
    dqu_in_word_t w;
    w.opcode     = op;
    w.push_value = val;
    return w;
  endfunction

  // Mostly random payloads, with the extremes mixed in.
  function automatic logic signed [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0: return WORD_MIN;
      1: return WORD_MAX;
      2: return '0;
      3: return -1;
      default: return $urandom;
    endcase
  endfunction

  // Fill runs lean on pushes, drain runs on pops, mixed runs use every code.
  function automatic dqu_in_word_t make_word(input stim_mode_e mode);
    int unsigned roll;
    logic [OP_W-1:0] op;
    roll = $urandom_range(0, 99);
    case (mode)
      MODE_FILL: begin
        if (roll < 45) op = OP_PUSH_FRONT;
        else if (roll < 88) op = OP_PUSH_BACK;
        else if (roll < 94) op = OP_POP_FRONT;
        else op = OP_POP_BACK;
      end
      MODE_DRAIN: begin
        if (roll < 6) op = OP_PUSH_FRONT;
        else if (roll < 12) op = OP_PUSH_BACK;
        else if (roll < 55) op = OP_POP_FRONT;
        else op = OP_POP_BACK;
      end
      default: begin
        if (roll < 22) op = OP_PUSH_FRONT;
        else if (roll < 44) op = OP_PUSH_BACK;
        else if (roll < 66) op = OP_POP_FRONT;
        else if (roll < 88) op = OP_POP_BACK;
        else if (roll < 94) op = OP_CLEAR;
        else op = OP_SPARE_LO + OP_W'($urandom_range(0, OP_SPARE_HI - OP_SPARE_LO));
      end
    endcase
    return word_of(op, pick_value());
  endfunction

  // Presents one word and waits for its handshake; unless steady is set, bursts end in random gaps.
  task automatic send_word(input dqu_in_word_t w);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = steady ? 0 : $urandom_range(1, 10);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk); while (in_ready !== 1'b1);
    burst_left--;
  endtask

  initial begin
    stim_mode_e  mode;
    int unsigned sent;
    int unsigned run_len;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: pops on an empty queue, extreme words, index wrap in both
    // directions from reset, unused codes and a clear with stale slots.
    steady = 1'b1;
    send_word(word_of(OP_POP_FRONT, WORD_MAX));
    send_word(word_of(OP_POP_BACK, WORD_MIN));
    send_word(word_of(OP_PUSH_FRONT, WORD_MIN));
    send_word(word_of(OP_PUSH_BACK, WORD_MAX));
    send_word(word_of(OP_PUSH_FRONT, -1));
    send_word(word_of(OP_PUSH_BACK, '0));
    send_word(word_of(OP_SPARE_LO, -1));
    send_word(word_of(OP_POP_BACK, '0));
    send_word(word_of(OP_POP_FRONT, '0));
    send_word(word_of(OP_SPARE_MID, WORD_MIN));
    send_word(word_of(OP_POP_BACK, -1));
    send_word(word_of(OP_POP_FRONT, -1));
    send_word(word_of(OP_POP_FRONT, '0));
    send_word(word_of(OP_PUSH_BACK, 32'sh5A5A_5A5A));
    send_word(word_of(OP_PUSH_FRONT, 32'shA5A5_A5A5));
    send_word(word_of(OP_CLEAR, -1));
    send_word(word_of(OP_POP_BACK, '0));
    send_word(word_of(OP_SPARE_HI, WORD_MAX));
    send_word(word_of(OP_PUSH_BACK, 32'sd1));
    send_word(word_of(OP_POP_FRONT, '0));

    // Random: runs of filling, draining and mixed traffic.
    sent = 0;
    while (sent < RANDOM_WORDS) begin
      case ($urandom_range(0, 2))
        0: mode = MODE_FILL;
        1: mode = MODE_DRAIN;
        default: mode = MODE_MIX;
      endcase
      steady  = ($urandom_range(0, 3) == 0);
      run_len = (mode == MODE_MIX) ? $urandom_range(6, 24) : $urandom_range(12, 32);
      repeat (run_len) begin
        send_word(make_word(mode));
        sent++;
      end
    end
    in_valid <= 1'b0;

    // Let the last results come out, then allow for stray extra words.
    @(posedge clk);
    while (tracker.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (tracker.mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+sv
sv/dqu_pkg.sv
sv/dqu_ctrl.sv
sv/dqu_dp.sv
sv/double_ended_queue_unit.sv
sv/dqu_checker.sv
dv/tb_double_ended_queue_unit.sv
